@@ sv/ghd_pkg.sv @@
// ghd_pkg: shared constants for the gf2 hankel determinant unit
// no dependencies
package ghd_pkg;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned CNT_MAX = 255;
endpackage

@@ sv/ghd_elim.sv @@
// ghd_elim: gf2 elimination engine, rows of the matrix held in a synchronous memory
// depends on ghd_pkg
module ghd_elim
    import ghd_pkg::*;
#(
    parameter int unsigned MAX_ORDER = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2*MAX_ORDER-2:0]    i_win,
    input  logic [$clog2(MAX_ORDER+1)-1:0] i_valid,
    output logic                      o_done,
    output logic [MAX_ORDER-1:0]      o_dets
);
    localparam int unsigned OW = $clog2(MAX_ORDER+1);
    localparam int unsigned AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_PRD = 4'd2,
                           S_PCHK = 4'd3, S_SWP = 4'd4, S_ERD = 4'd5,
                           S_EWR = 4'd6, S_NEXT = 4'd7, S_DONE = 4'd8;

    // row memory, one row per matrix row
    logic [MAX_ORDER-1:0] r_mem [MAX_ORDER];
    logic [MAX_ORDER-1:0] r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa, mem_ra;
    logic [MAX_ORDER-1:0] mem_wd;

    logic [3:0]           r_st, n_st;
    logic [OW-1:0]        r_j, r_c, r_r, r_k;
    logic [MAX_ORDER-1:0] r_piv, r_dets;
    logic                 r_done;
    logic [OW-1:0]        n_j, n_c, n_r, n_k;
    logic [MAX_ORDER-1:0] n_piv, n_dets;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    // window row r, masked to j columns
    function automatic logic [MAX_ORDER-1:0] wrow(input logic [2*MAX_ORDER-2:0] w,
                                                  input logic [OW-1:0] r,
                                                  input logic [OW-1:0] j);
        logic [2*MAX_ORDER-2:0] s;
        logic [MAX_ORDER-1:0]   m;
        s = w >> r;
        m = (j >= OW'(MAX_ORDER)) ? '1 : ((MAX_ORDER'(1) << j) - MAX_ORDER'(1));
        return s[MAX_ORDER-1:0] & m;
    endfunction

    logic [MAX_ORDER-1:0] cbit;
    assign cbit = MAX_ORDER'(1) << r_c[AW-1:0];

    always_comb begin
        n_st = r_st; n_j = r_j; n_c = r_c; n_r = r_r; n_k = r_k;
        n_piv = r_piv; n_dets = r_dets;
        mem_we = 1'b0; mem_wa = r_r[AW-1:0]; mem_wd = '0; mem_ra = r_r[AW-1:0];
        unique case (r_st)
            S_IDLE: if (i_start) begin
                n_dets = '0; n_j = OW'(1); n_r = '0;
                n_st = (i_valid == '0) ? S_DONE : S_LOAD;
            end
            // load j rows, one per cycle
            S_LOAD: begin
                mem_we = 1'b1; mem_wa = r_r[AW-1:0];
                mem_wd = wrow(i_win, r_r, r_j);
                if (r_r == r_j - OW'(1)) begin
                    n_c = '0; n_r = '0; n_st = S_PRD;
                end else n_r = r_r + OW'(1);
            end
            // pivot search from row c
            S_PRD: begin mem_ra = r_r[AW-1:0]; n_st = S_PCHK; end
            S_PCHK: begin
                if ((r_rdata & cbit) != '0) begin
                    n_piv = r_rdata; mem_ra = r_c[AW-1:0]; n_st = S_SWP;
                end else if (r_r == r_j - OW'(1)) begin
                    n_st = S_NEXT;
                end else begin
                    n_r = r_r + OW'(1); mem_ra = n_r[AW-1:0]; n_st = S_PCHK;
                end
            end
            // move old row c to pivot row; row c held in r_piv
            S_SWP: begin
                mem_we = 1'b1; mem_wa = r_r[AW-1:0]; mem_wd = r_rdata;
                n_k = r_c + OW'(1);
                if (r_c == r_j - OW'(1)) begin
                    n_dets = r_dets | (MAX_ORDER'(1) << (r_j - OW'(1)));
                    n_st = S_NEXT;
                end else n_st = S_ERD;
            end
            S_ERD: begin mem_ra = r_k[AW-1:0]; n_st = S_EWR; end
            S_EWR: begin
                mem_we = 1'b1; mem_wa = r_k[AW-1:0];
                mem_wd = ((r_rdata & cbit) != '0) ? (r_rdata ^ r_piv) : r_rdata;
                if (r_k == r_j - OW'(1)) begin
                    n_c = r_c + OW'(1); n_r = r_c + OW'(1); n_st = S_PRD;
                end else begin
                    n_k = r_k + OW'(1); n_st = S_ERD;
                end
            end
            S_NEXT: begin
                if (r_j == i_valid) n_st = S_DONE;
                else begin n_j = r_j + OW'(1); n_r = '0; n_st = S_LOAD; end
            end
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_done <= 1'b0;
        end else begin
            r_st <= n_st; r_done <= (r_st == S_DONE);
        end
        r_j <= n_j; r_c <= n_c; r_r <= n_r; r_k <= n_k;
        r_piv <= n_piv; r_dets <= n_dets;
    end

    assign o_done = r_done;
    assign o_dets = r_dets;

    // a row write only while loading, swapping or eliminating
    a_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_st == S_LOAD || r_st == S_SWP || r_st == S_EWR))
        else $error("row write outside load or elimination");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_st == S_IDLE)) else $error("done while busy");
    a_ord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_LOAD) |-> (r_j <= i_valid)) else $error("order beyond valid");
endmodule

@@ sv/gf2_hankel_determinant_diagonal_unit.sv @@
// gf2_hankel_determinant_diagonal_unit: top level, window, count, result register
// depends on ghd_pkg and ghd_elim
//
// usage: s_axis carries one sequence bit per transfer, tdata = {restart, seq_bit}
// (bit 0 seq_bit, bit 1 restart). after each accepted bit the unit computes one
// anti-diagonal of the gf2 number wall and offers it on m_axis:
// tdata bits 63:0 det_bits, bits 70:64 valid_orders, bit 71 zero.
// order j costs least when the first column holds no pivot. the time is set by
// the elimination sequencer, which reloads the j rows of each order and reads
// or writes one 64-bit row of the row memory per cycle.
// the next bit is taken once elimination is done and the result register is free
// to load; a stalled receiver holds the result and blocks new bits.
// order_limit must be written on the cfg channel only while idle; the unit does
// not enforce this. reset sets it to 64, clears the window and count, and drops
// all valid flags.
module gf2_hankel_determinant_diagonal_unit
    import ghd_pkg::*;
#(
    parameter int unsigned MAX_ORDER = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,  // seq_bit, restart
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [MAX_ORDER+7:0]     m_axis_tdata,  // det_bits, valid_orders
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_data
);
    localparam int unsigned OW = $clog2(MAX_ORDER+1);
    localparam int unsigned WL = 2*MAX_ORDER-1;

    logic [WL-1:0]     r_win;
    logic [CNT_W-1:0]  r_seen;
    logic [CFG_W-1:0]  r_limit;
    logic [OW-1:0]     r_valid;
    logic              r_busy, r_ovld, r_start;
    logic [MAX_ORDER-1:0] r_dets;
    logic              done;
    logic [MAX_ORDER-1:0] dets;

    logic in_xfer;
    assign s_axis_tready = !r_busy && !r_ovld;
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // next window, count, valid order count
    logic [WL-1:0]    n_win;
    logic [CNT_W-1:0] n_seen;
    logic [CFG_W-1:0] lim;
    logic [CNT_W-1:0] half;
    logic [OW-1:0]    n_valid;
    always_comb begin
        n_win  = s_axis_tdata[1] ? WL'(s_axis_tdata[0])
                                 : {r_win[WL-2:0], s_axis_tdata[0]};
        n_seen = s_axis_tdata[1] ? CNT_W'(1)
                 : ((r_seen == CNT_W'(CNT_MAX)) ? r_seen : r_seen + CNT_W'(1));
        lim    = (r_limit > CFG_W'(MAX_ORDER)) ? CFG_W'(MAX_ORDER) : r_limit;
        half   = CNT_W'((9'(n_seen) + 9'd1) >> 1);
        n_valid = (half > CNT_W'(lim)) ? OW'(lim) : OW'(half);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0; r_seen <= '0; r_limit <= CFG_W'(64);
            r_busy <= 1'b0; r_ovld <= 1'b0; r_start <= 1'b0;
        end else begin
            r_start <= in_xfer;
            if (i_cfg_valid) r_limit <= i_cfg_data;
            if (in_xfer) begin
                r_win <= n_win; r_seen <= n_seen; r_busy <= 1'b1;
            end
            if (done) begin r_busy <= 1'b0; r_ovld <= 1'b1; end
            else if (m_axis_tready) r_ovld <= 1'b0;
        end
        if (in_xfer) r_valid <= n_valid;
        if (done) r_dets <= dets;
    end

    ghd_elim #(.MAX_ORDER(MAX_ORDER)) u_elim (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_win(r_win), .i_valid(r_valid), .o_done(done), .o_dets(dets)
    );

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {(8 - OW)'(0), r_valid, r_dets};

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready) else $error("input taken while busy");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> r_busy) else $error("done without a bit in work");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !m_axis_tready) |=> r_ovld) else $error("result dropped");
endmodule

@@ bench/ghd_checker.sv @@
// ghd_checker: watches the bit, result and cfg channels of the gf2 hankel unit,
// predicts each anti-diagonal and compares it; depends on ghd_pkg only
module ghd_checker
    import ghd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // seq_bit, restart
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [71:0]  m_axis_tdata,   // det_bits, valid_orders
    input  logic         i_cfg_valid,
    input  logic         o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ORDERS = 64;

    typedef struct packed {
        logic [63:0] det_bits;
        logic [6:0]  valid_orders;
    } t_diag;

    t_diag             diag_queue[$];
    bit [126:0]        seq_window;   // entry 0 newest
    bit [CNT_W-1:0]    seen_count;
    bit [CFG_W-1:0]    limit_reg;

    // determinant over gf2 by elimination, column c pivots on bit c
    function automatic bit gf2_det(bit [63:0] rows[ORDERS], int n);
        bit [63:0] t;
        int r;
        for (int c = 0; c < n; c++) begin
            r = c;
            while (r < n && rows[r][c] == 1'b0) r++;
            if (r >= n) return 1'b0;
            if (r != c) begin
                t = rows[r];
                rows[r] = rows[c];
                rows[c] = t;
            end
            for (int k = c + 1; k < n; k++)
                if (rows[k][c]) rows[k] ^= rows[c];
        end
        return 1'b1;
    endfunction

    // one anti-diagonal from the current window and count
    function automatic t_diag diagonal(bit [126:0] w, int cnt, int lim);
        t_diag d;
        bit [63:0] rows[ORDERS];
        bit [63:0] mask;
        int valid;
        if (lim > ORDERS) lim = ORDERS;
        valid = (cnt + 1) / 2;
        if (valid > lim) valid = lim;
        d.det_bits = '0;
        d.valid_orders = valid[6:0];
        for (int j = 1; j <= valid; j++) begin
            mask = (j >= 64) ? '1 : ((64'd1 << j) - 64'd1);
            for (int r = 0; r < j; r++) rows[r] = 64'(w >> r) & mask;
            if (gf2_det(rows, j)) d.det_bits[j-1] = 1'b1;
        end
        return d;
    endfunction

    assign o_pending = diag_queue.size();

    always @(posedge i_clk) begin
        t_diag got;
        t_diag want;
        if (!i_rst_n) begin
            seq_window     <= '0;
            seen_count     <= '0;
            limit_reg      <= 7'd64;
            o_fail_count   <= 0;
            o_results_seen <= 0;
            diag_queue.delete();
        end else begin
            bit [126:0]     w;
            bit [CNT_W-1:0] c;
            // cfg transfer
            if (i_cfg_valid && o_cfg_ready) limit_reg <= i_cfg_data;
            // bit transfer: update history and predict
            if (s_axis_tvalid && s_axis_tready) begin
                w = seq_window;
                c = seen_count;
                if (s_axis_tdata[1]) begin
                    w = '0;
                    c = '0;
                end
                w = {w[125:0], s_axis_tdata[0]};
                if (c < CNT_MAX) c++;
                seq_window <= w;
                seen_count <= c;
                diag_queue.insert(diag_queue.size(),
                                  diagonal(w, int'(c), int'(limit_reg)));
            end
            // result transfer
            if (m_axis_tvalid && m_axis_tready) begin
                got.det_bits     = m_axis_tdata[63:0];
                got.valid_orders = m_axis_tdata[70:64];
                o_results_seen <= o_results_seen + 1;
                if (diag_queue.size() == 0) begin
                    $display("%0t: unexpected result det %h valid %0d", $time,
                             got.det_bits, got.valid_orders);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = diag_queue.pop_front();
                    if (want.det_bits !== got.det_bits ||
                        want.valid_orders !== got.valid_orders ||
                        m_axis_tdata[71] !== 1'b0) begin
                        $display("%0t: mismatch: want det %h valid %0d, got det %h valid %0d pad %b",
                                 $time, want.det_bits, want.valid_orders,
                                 got.det_bits, got.valid_orders, m_axis_tdata[71]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ bench/gf2_hankel_determinant_diagonal_unit_test.sv @@
// gf2_hankel_determinant_diagonal_unit_test: stimulus and verdict for the unit
// depends on ghd_pkg, ghd_checker and gf2_hankel_determinant_diagonal_unit
module gf2_hankel_determinant_diagonal_unit_test;
    import ghd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // seq_bit, restart
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [71:0]       m_axis_tdata;        // det_bits, valid_orders
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    int fail_count, pending, results_seen;
    int idle_pct = 0, stall_pct = 0;
    int bits_sent = 0;
    int wait_cycles;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    gf2_hankel_determinant_diagonal_unit #(.MAX_ORDER(64)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    ghd_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    // receiver backpressure
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // one bit transfer, with random idle cycles first
    task automatic send_bit(input bit seq, input bit restart);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, restart, seq};
        do @(posedge i_clk); while (!s_axis_tready);
        bits_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    // limit write, only with nothing in flight
    task automatic set_limit(input bit [CFG_W-1:0] v);
        drain();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int lims[6] = '{2, 5, 8, 12, 20, 33};
        int idles[4] = '{0, 45, 0, 22};
        int stalls[4] = '{0, 0, 45, 22};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default limit, short history from a restart
        send_bit(1, 1); send_bit(0, 0); send_bit(1, 0); send_bit(1, 0);
        send_bit(0, 0); send_bit(1, 0); send_bit(1, 1); send_bit(1, 0);
        // limit zero reports no valid orders
        set_limit(7'd0);
        send_bit(1, 0); send_bit(0, 1); send_bit(1, 0);
        // limit above max acts as max, all cfg bits set
        set_limit(7'd127);
        send_bit(1, 1); send_bit(1, 0); send_bit(0, 0); send_bit(1, 0); send_bit(0, 0);

        // long run under a cheap limit, history continues: count saturates
        set_limit(7'd1);
        for (int i = 0; i < 254; i++) send_bit(1'($urandom_range(1)), 0);
        // full 64 orders on a saturated history
        set_limit(7'd64);
        for (int i = 0; i < 4; i++) send_bit(1'($urandom_range(1)), 0);

        // random phases over idle and stall mixes and small limits
        for (int p = 0; p < 4; p++) begin
            set_limit(CFG_W'(lims[$urandom_range(5)]));
            idle_pct  = idles[p];
            stall_pct = stalls[p];
            for (int i = 0; i < 6; i++) begin
                if (i == 3) begin
                    // hold off until the pipeline is empty
                    drain();
                    set_limit(CFG_W'(lims[$urandom_range(5)]));
                end
                send_bit(1'($urandom_range(1)), $urandom_range(11) == 0);
            end
        end

        drain();
        idle_pct = 0;
        stall_pct = 0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        $display("covered %0d bits and %0d results: limits 0, 1, small, 64 and 127,",
                 bits_sent, results_seen);
        $display("restarts, count saturation and four idle and stall mixes");
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit
    initial begin
        #200ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ files.f @@
sv/ghd_pkg.sv
sv/ghd_elim.sv
sv/gf2_hankel_determinant_diagonal_unit.sv
bench/ghd_checker.sv
bench/gf2_hankel_determinant_diagonal_unit_test.sv
